// File: hw/rtl/fq_pkg.sv
// Shared types, codes and the normalize helper for the float to int quantizer.
// Used by fq_dsub, fq_mulq, float_to_int_quantizer and the bench; depends on nothing.

package fq_pkg;

    localparam logic [1:0] FMT_HALF   = 2'd0;
    localparam logic [1:0] FMT_SINGLE = 2'd1;
    localparam logic [1:0] FMT_DOUBLE = 2'd2;

    localparam logic [1:0] TW_INT8  = 2'd0;
    localparam logic [1:0] TW_INT16 = 2'd1;
    localparam logic [1:0] TW_INT32 = 2'd2;

    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_FORMAT = 2'd2;
    localparam logic [1:0] CFG_TWIDTH = 2'd3;

    // class of an operand or intermediate result
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } fclass_t;

    typedef struct packed {
        logic [6:0]  cnt;
        logic [63:0] val;
    } norm_t;

    // leading-zero count and left-justify in six halving steps
    function automatic norm_t norm64(input logic [63:0] x);
        norm_t       r;
        logic [63:0] v;
        logic [6:0]  c;
        v = x;
        c = '0;
        if (v[63:32] == 32'd0) begin
            v = {v[31:0], 32'd0};
            c = c + 7'd32;
        end
        if (v[63:48] == 16'd0) begin
            v = {v[47:0], 16'd0};
            c = c + 7'd16;
        end
        if (v[63:56] == 8'd0) begin
            v = {v[55:0], 8'd0};
            c = c + 7'd8;
        end
        if (v[63:60] == 4'd0) begin
            v = {v[59:0], 4'd0};
            c = c + 7'd4;
        end
        if (v[63:62] == 2'd0) begin
            v = {v[61:0], 2'd0};
            c = c + 7'd2;
        end
        if (v[63] == 1'b0) begin
            v = {v[62:0], 1'b0};
            c = c + 7'd1;
        end
        r.cnt = c;
        r.val = v;
        return r;
    endfunction

endpackage

// File: hw/rtl/float_to_int_quantizer.sv
// Affine float to int quantizer: accepts one sample per clock while s_tready is high
// and returns one result per sample, in order, through the pipeline: input register,
// format widening, a four-stage double subtractor and a six-stage split multiplier
// with round and clamp. The whole pipe advances whenever the output register is empty
// or being taken, so s_tready follows m_tready.
// Write configuration only while no transaction is in flight.
// Depends on fq_pkg, fq_dsub and fq_mulq.

module float_to_int_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] raw_sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] quantized
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NST = 12;

    logic [63:0] scale_reg, offset_reg;
    logic [1:0]  format_reg, twidth_reg;
    logic        en;
    logic [NST-1:0] vld_reg, last_reg;

    assign en        = ~m_tvalid | m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NST-1];
    assign m_tlast   = last_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= 64'h3FF0_0000_0000_0000;
            offset_reg <= 64'd0;
            format_reg <= fq_pkg::FMT_SINGLE;
            twidth_reg <= fq_pkg::TW_INT8;
        end else if (cfg_valid) begin
            case (cfg_index)
                fq_pkg::CFG_SCALE:  scale_reg  <= cfg_data;
                fq_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                fq_pkg::CFG_FORMAT: format_reg <= cfg_data[1:0];
                fq_pkg::CFG_TWIDTH: twidth_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[NST-2:0], s_tlast};
        end
    end

    // input register
    logic [63:0] raw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg <= s_tdata;
        end
    end

    // widen half or single to double, exactly
    logic        ws;
    logic [7:0]  we;
    logic [22:0] wm;
    logic        w_half;
    fq_pkg::norm_t wn;
    logic [63:0] v_next, v_reg;

    always_comb begin
        w_half = (format_reg == fq_pkg::FMT_HALF);
        if (w_half) begin
            ws = raw_reg[15];
            we = {3'd0, raw_reg[14:10]};
            wm = {raw_reg[9:0], 13'd0};
        end else begin
            ws = raw_reg[31];
            we = raw_reg[30:23];
            wm = raw_reg[22:0];
        end
        wn = fq_pkg::norm64({wm, 41'd0});
        if (format_reg != fq_pkg::FMT_HALF && format_reg != fq_pkg::FMT_SINGLE) begin
            v_next = raw_reg;
        end else if ((w_half && we == 8'd31) || (!w_half && we == 8'd255)) begin
            v_next = {ws, 11'h7FF, wm != 23'd0, 51'd0};
        end else if (we == 8'd0) begin
            if (wm == 23'd0) begin
                v_next = {ws, 63'd0};
            end else if (w_half) begin
                v_next = {ws, 11'd1008 - {4'd0, wn.cnt}, wn.val[62:11]};
            end else begin
                v_next = {ws, 11'd896 - {4'd0, wn.cnt}, wn.val[62:11]};
            end
        end else if (w_half) begin
            v_next = {ws, {3'd0, we} + 11'd1008, wm[22:13], 42'd0};
        end else begin
            v_next = {ws, {3'd0, we} + 11'd896, wm, 29'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
        end
    end

    // scale in left-normalized form, refreshed every cycle
    fq_pkg::norm_t      sn;
    fq_pkg::fclass_t    sc_cls_next, sc_cls_reg;
    logic signed [12:0] sc_exp_next, sc_exp_reg;
    logic [52:0]        sc_man_next, sc_man_reg;

    always_comb begin
        sn = fq_pkg::norm64({1'b0, scale_reg[51:0], 11'd0});
        sc_cls_next.nan  = (&scale_reg[62:52]) & (|scale_reg[51:0]);
        sc_cls_next.inf  = (&scale_reg[62:52]) & ~(|scale_reg[51:0]);
        sc_cls_next.zero = (scale_reg[62:0] == 63'd0);
        sc_cls_next.sign = scale_reg[63];
        if (scale_reg[62:52] == 11'd0) begin
            sc_man_next = sn.val[63:11];
            sc_exp_next = 13'sd1 - $signed({6'd0, sn.cnt});
        end else begin
            sc_man_next = {1'b1, scale_reg[51:0]};
            sc_exp_next = $signed({2'b00, scale_reg[62:52]});
        end
    end

    always_ff @(posedge aclk) begin
        sc_cls_reg <= sc_cls_next;
        sc_exp_reg <= sc_exp_next;
        sc_man_reg <= sc_man_next;
    end

    fq_pkg::fclass_t    d_cls;
    logic signed [12:0] d_exp;
    logic [52:0]        d_man;

    fq_dsub u_dsub (
        .aclk     (aclk),
        .en       (en),
        .v_bits   (v_reg),
        .off_bits (offset_reg),
        .d_cls    (d_cls),
        .d_exp    (d_exp),
        .d_man    (d_man)
    );

    fq_mulq u_mulq (
        .aclk  (aclk),
        .en    (en),
        .d_cls (d_cls),
        .d_exp (d_exp),
        .d_man (d_man),
        .s_cls (sc_cls_reg),
        .s_exp (sc_exp_reg),
        .s_man (sc_man_reg),
        .tw    (twidth_reg),
        .q     (m_tdata)
    );

endmodule

// File: hw/rtl/fq_dsub.sv
// Four-stage double precision subtractor (value minus offset), round to nearest even.
// Depends on fq_pkg. Result is left-normalized with an extended signed biased exponent.

module fq_dsub (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [63:0]           v_bits,
    input  logic [63:0]           off_bits,
    output fq_pkg::fclass_t       d_cls,
    output logic signed [12:0]    d_exp,
    output logic [52:0]           d_man
);

    // stage A: classify, order by magnitude, align
    logic        sv, so, sb;
    logic [10:0] ev, eo, ev_eff, eo_eff;
    logic [51:0] fv, fo;
    logic [52:0] mv, mo;
    logic        v_nan, v_inf, o_nan, o_inf, swap;
    logic        sa, sbb;
    logic [10:0] ea, eb, diff;
    logic [52:0] ma, mb;
    logic [55:0] ext, shifted, mask, bal;
    fq_pkg::fclass_t a_cls_next;

    fq_pkg::fclass_t a_cls_reg;
    logic            a_sign_reg, a_sub_reg;
    logic [10:0]     a_exp_reg;
    logic [55:0]     a_ma_reg, a_mb_reg;

    always_comb begin
        sv = v_bits[63];
        ev = v_bits[62:52];
        fv = v_bits[51:0];
        so = off_bits[63];
        eo = off_bits[62:52];
        fo = off_bits[51:0];
        sb = ~so;
        v_nan = (&ev) & (|fv);
        v_inf = (&ev) & ~(|fv);
        o_nan = (&eo) & (|fo);
        o_inf = (&eo) & ~(|fo);
        ev_eff = (ev == 11'd0) ? 11'd1 : ev;
        eo_eff = (eo == 11'd0) ? 11'd1 : eo;
        mv = {ev != 11'd0, fv};
        mo = {eo != 11'd0, fo};
        swap = {eo_eff, mo} > {ev_eff, mv};
        sa  = swap ? sb : sv;
        sbb = swap ? sv : sb;
        ea  = swap ? eo_eff : ev_eff;
        eb  = swap ? ev_eff : eo_eff;
        ma  = swap ? mo : mv;
        mb  = swap ? mv : mo;
        diff = ea - eb;
        ext = {mb, 3'b000};
        shifted = ext >> diff;
        mask = (56'd1 << diff) - 56'd1;
        if (diff > 11'd55) begin
            bal = {55'd0, |mb};
        end else begin
            bal = {shifted[55:1], shifted[0] | (|(ext & mask))};
        end
        a_cls_next.nan  = v_nan | o_nan | (v_inf & o_inf & (sv == so));
        a_cls_next.inf  = v_inf | o_inf;
        a_cls_next.zero = 1'b0;
        a_cls_next.sign = v_inf ? sv : sb;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_cls_reg  <= a_cls_next;
            a_sign_reg <= sa;
            a_sub_reg  <= sa ^ sbb;
            a_exp_reg  <= ea;
            a_ma_reg   <= {ma, 3'b000};
            a_mb_reg   <= bal;
        end
    end

    // stage B: add or subtract magnitudes
    fq_pkg::fclass_t b_cls_reg;
    logic            b_sign_reg;
    logic [10:0]     b_exp_reg;
    logic [56:0]     b_sum_reg;
    logic [56:0]     b_sum_next;

    assign b_sum_next = a_sub_reg ? ({1'b0, a_ma_reg} - {1'b0, a_mb_reg})
                                  : ({1'b0, a_ma_reg} + {1'b0, a_mb_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            b_cls_reg  <= a_cls_reg;
            b_sign_reg <= a_sign_reg;
            b_exp_reg  <= a_exp_reg;
            b_sum_reg  <= b_sum_next;
        end
    end

    // stage C: normalize
    fq_pkg::norm_t      nrm;
    logic [55:0]        c_n_next;
    logic signed [12:0] c_exp_next;
    fq_pkg::fclass_t    c_cls_next;

    fq_pkg::fclass_t    c_cls_reg;
    logic               c_sign_reg;
    logic signed [12:0] c_exp_reg;
    logic [55:0]        c_n_reg;

    always_comb begin
        nrm = fq_pkg::norm64({b_sum_reg[55:0], 8'd0});
        if (b_sum_reg[56]) begin
            c_n_next   = {b_sum_reg[56:2], b_sum_reg[1] | b_sum_reg[0]};
            c_exp_next = $signed({2'b00, b_exp_reg}) + 13'sd1;
        end else begin
            c_n_next   = nrm.val[63:8];
            c_exp_next = $signed({2'b00, b_exp_reg}) - $signed({6'd0, nrm.cnt});
        end
        c_cls_next      = b_cls_reg;
        c_cls_next.zero = (b_sum_reg == 57'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cls_reg  <= c_cls_next;
            c_sign_reg <= b_sign_reg;
            c_exp_reg  <= c_exp_next;
            c_n_reg    <= c_n_next;
        end
    end

    // stage D: round to nearest even
    logic [52:0]        m53;
    logic [53:0]        rnd;
    logic               up, ovf;
    logic signed [12:0] r_exp;
    fq_pkg::fclass_t    d_cls_next;
    logic [52:0]        d_man_next;

    fq_pkg::fclass_t    d_cls_reg;
    logic signed [12:0] d_exp_reg;
    logic [52:0]        d_man_reg;

    always_comb begin
        m53 = c_n_reg[55:3];
        up  = c_n_reg[2] & ((|c_n_reg[1:0]) | m53[0]);
        rnd = {1'b0, m53} + {53'd0, up};
        if (rnd[53]) begin
            d_man_next = rnd[53:1];
            r_exp      = c_exp_reg + 13'sd1;
        end else begin
            d_man_next = rnd[52:0];
            r_exp      = c_exp_reg;
        end
        ovf = (r_exp >= 13'sd2047);
        d_cls_next.nan  = c_cls_reg.nan;
        d_cls_next.inf  = ~c_cls_reg.nan & (c_cls_reg.inf | (ovf & ~c_cls_reg.zero));
        d_cls_next.zero = ~c_cls_reg.nan & ~c_cls_reg.inf & c_cls_reg.zero;
        d_cls_next.sign = c_cls_reg.inf ? c_cls_reg.sign : c_sign_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_cls_reg <= d_cls_next;
            d_exp_reg <= r_exp;
            d_man_reg <= d_man_next;
        end
    end

    assign d_cls = d_cls_reg;
    assign d_exp = d_exp_reg;
    assign d_man = d_man_reg;

endmodule

// File: hw/rtl/fq_mulq.sv
// Six-stage double multiply by the scale, then round half away and clamp to the target.
// Depends on fq_pkg. Operands arrive left-normalized with signed biased exponents.

module fq_mulq (
    input  logic                  aclk,
    input  logic                  en,
    input  fq_pkg::fclass_t       d_cls,
    input  logic signed [12:0]    d_exp,
    input  logic [52:0]           d_man,
    input  fq_pkg::fclass_t       s_cls,
    input  logic signed [12:0]    s_exp,
    input  logic [52:0]           s_man,
    input  logic [1:0]            tw,
    output logic [31:0]           q
);

    // stage 1: partial products and product class
    fq_pkg::fclass_t    e_cls_next;
    fq_pkg::fclass_t    e_cls_reg;
    logic signed [13:0] e_exp_reg;
    logic [51:0]        pp_hh_reg;
    logic [52:0]        pp_hl_reg, pp_lh_reg;
    logic [53:0]        pp_ll_reg;

    always_comb begin
        e_cls_next.nan  = d_cls.nan | s_cls.nan | (d_cls.inf & s_cls.zero)
                        | (d_cls.zero & s_cls.inf);
        e_cls_next.inf  = d_cls.inf | s_cls.inf;
        e_cls_next.zero = d_cls.zero | s_cls.zero;
        e_cls_next.sign = d_cls.sign ^ s_cls.sign;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_cls_reg <= e_cls_next;
            e_exp_reg <= $signed({d_exp[12], d_exp}) + $signed({s_exp[12], s_exp})
                       - 14'sd2150;
            pp_hh_reg <= d_man[52:27] * s_man[52:27];
            pp_hl_reg <= d_man[52:27] * s_man[26:0];
            pp_lh_reg <= d_man[26:0] * s_man[52:27];
            pp_ll_reg <= d_man[26:0] * s_man[26:0];
        end
    end

    // stage 2: middle sum
    fq_pkg::fclass_t    f_cls_reg;
    logic signed [13:0] f_exp_reg;
    logic [105:0]       f_outer_reg;
    logic [53:0]        f_mid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_cls_reg   <= e_cls_reg;
            f_exp_reg   <= e_exp_reg;
            f_outer_reg <= {pp_hh_reg, pp_ll_reg};
            f_mid_reg   <= {1'b0, pp_hl_reg} + {1'b0, pp_lh_reg};
        end
    end

    // stage 3: full product
    fq_pkg::fclass_t    g_cls_reg;
    logic signed [13:0] g_exp_reg;
    logic [105:0]       g_p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            g_cls_reg <= f_cls_reg;
            g_exp_reg <= f_exp_reg;
            g_p_reg   <= f_outer_reg + {25'd0, f_mid_reg, 27'd0};
        end
    end

    // stage 4: normalize and round the product to double
    logic [52:0]        pm;
    logic               pg, pst, pup;
    logic [53:0]        prnd;
    logic signed [13:0] pe;
    logic [52:0]        h_man_next;
    logic signed [13:0] h_exp_next;

    fq_pkg::fclass_t    h_cls_reg;
    logic signed [13:0] h_exp_reg;
    logic [52:0]        h_man_reg;

    always_comb begin
        if (g_p_reg[105]) begin
            pm  = g_p_reg[105:53];
            pg  = g_p_reg[52];
            pst = |g_p_reg[51:0];
            pe  = g_exp_reg + 14'sd53;
        end else begin
            pm  = g_p_reg[104:52];
            pg  = g_p_reg[51];
            pst = |g_p_reg[50:0];
            pe  = g_exp_reg + 14'sd52;
        end
        pup  = pg & (pst | pm[0]);
        prnd = {1'b0, pm} + {53'd0, pup};
        if (prnd[53]) begin
            h_man_next = prnd[53:1];
            h_exp_next = pe + 14'sd1;
        end else begin
            h_man_next = prnd[52:0];
            h_exp_next = pe;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_cls_reg <= g_cls_reg;
            h_exp_reg <= h_exp_next;
            h_man_reg <= h_man_next;
        end
    end

    // stage 5: keep integer part plus one fraction bit
    logic               big, tiny;
    logic signed [13:0] nsh;
    logic [5:0]         sh;
    logic [52:0]        tw_shift;

    fq_pkg::fclass_t    k_cls_reg;
    logic               k_big_reg, k_tiny_reg;
    logic [32:0]        k_t_reg;

    always_comb begin
        big  = (h_exp_reg >= -14'sd20);
        tiny = (h_exp_reg <= -14'sd54);
        nsh  = -h_exp_reg - 14'sd1;
        sh   = nsh[5:0];
        tw_shift = h_man_reg >> sh;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_cls_reg  <= h_cls_reg;
            k_big_reg  <= big;
            k_tiny_reg <= tiny;
            k_t_reg    <= tw_shift[32:0];
        end
    end

    // stage 6: round half away from zero, clamp, sign
    logic [33:0] tp1;
    logic [32:0] mag;
    logic [31:0] hi, lo, q_next;

    always_comb begin
        tp1 = {1'b0, k_t_reg} + 34'd1;
        mag = tp1[33:1];
        case (tw)
            fq_pkg::TW_INT8:  hi = 32'h0000_007F;
            fq_pkg::TW_INT16: hi = 32'h0000_7FFF;
            default:          hi = 32'h7FFF_FFFF;
        endcase
        lo = ~hi;
        if (k_cls_reg.nan) begin
            q_next = lo;
        end else if (k_cls_reg.inf || (k_big_reg && !k_cls_reg.zero)) begin
            q_next = k_cls_reg.sign ? lo : hi;
        end else if (k_cls_reg.zero || k_tiny_reg) begin
            q_next = 32'd0;
        end else if (!k_cls_reg.sign) begin
            q_next = (mag > {1'b0, hi}) ? hi : mag[31:0];
        end else begin
            q_next = (mag > ({1'b0, hi} + 33'd1)) ? lo : (32'd0 - mag[31:0]);
        end
    end

    logic [31:0] q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: tb/sv/float_to_int_quantizer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for float_to_int_quantizer: random and directed samples through
// the stream ports, predicted in double precision and compared in order. Needs fq_pkg.

module float_to_int_quantizer_tb;

    typedef struct {
        logic [63:0] raw;
        logic        last;
    } sample_t;

    typedef struct {
        logic [31:0] quantized;
        logic        last;
    } quant_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    float_to_int_quantizer uut (.*);

    // configuration as the block should hold it
    logic [63:0] scale_reg;
    logic [63:0] offset_reg;
    logic [1:0]  format_reg;
    logic [1:0]  width_reg;

    sample_t sample_q[$];
    quant_t  quant_q[$];
    int      fail_count;
    bit      tx_burst;
    bit      rx_burst;
    bit      hold_req;
    int      tx_gap;
    int      rx_wait;
    int      hold_left;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic bit is_nan(real r);
        logic [63:0] b;
        b = $realtobits(r);
        return b[62:52] == 11'h7FF && b[51:0] != 0;
    endfunction

    function automatic real widen(logic [63:0] raw, logic [1:0] fmt);
        logic [63:0] sgn;
        int          ex;
        logic [51:0] man;
        real         d;
        if (fmt == fq_pkg::FMT_HALF) begin
            sgn = {raw[15], 63'd0};
            ex  = int'(raw[14:10]);
            man = {raw[9:0], 42'd0};
            if (ex == 31) return $bitstoreal(sgn | (man != 0 ? 64'h7FF8000000000000
                                                             : 64'h7FF0000000000000));
            if (ex == 0) begin
                d = raw[9:0] * $bitstoreal(64'(1023 - 24) << 52);
                return raw[15] ? -d : d;
            end
            return $bitstoreal(sgn | (64'(ex - 15 + 1023) << 52) | 64'(man));
        end else if (fmt == fq_pkg::FMT_SINGLE) begin
            sgn = {raw[31], 63'd0};
            ex  = int'(raw[30:23]);
            man = {raw[22:0], 29'd0};
            if (ex == 255) return $bitstoreal(sgn | (man != 0 ? 64'h7FF8000000000000
                                                              : 64'h7FF0000000000000));
            if (ex == 0) begin
                d = raw[22:0] * $bitstoreal(64'(1023 - 149) << 52);
                return raw[31] ? -d : d;
            end
            return $bitstoreal(sgn | (64'(ex - 127 + 1023) << 52) | 64'(man));
        end
        return $bitstoreal(raw);
    endfunction

    function automatic logic [31:0] quantize(logic [63:0] raw);
        real    v;
        real    p;
        real    lo;
        real    hi;
        real    a;
        longint q;
        v = widen(raw, format_reg);
        if (width_reg == fq_pkg::TW_INT8) begin
            lo = -128.0;
            hi = 127.0;
        end else if (width_reg == fq_pkg::TW_INT16) begin
            lo = -32768.0;
            hi = 32767.0;
        end else begin
            lo = -2147483648.0;
            hi = 2147483647.0;
        end
        if (is_nan(v)) begin
            q = longint'(lo);
        end else begin
            p = (v - $bitstoreal(offset_reg)) * $bitstoreal(scale_reg);
            if (is_nan(p)) q = longint'(lo);
            else if (p >= hi + 0.5) q = longint'(hi);
            else if (p <= lo - 0.5) q = longint'(lo);
            else begin
                a = p < 0.0 ? -p : p;
                q = longint'($floor(a));
                if (a - real'(q) >= 0.5) q++;
                if (p < 0.0) q = -q;
                if (real'(q) < lo) q = longint'(lo);
                if (real'(q) > hi) q = longint'(hi);
            end
        end
        return q[31:0];
    endfunction

    // sender: one gap drawn per sample
    always @(posedge aclk) begin
        sample_t cur;
        quant_t  want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                want.quantized = quantize(s_tdata);
                want.last      = s_tlast;
                quant_q.push_back(want);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur.raw;
                    s_tlast  <= cur.last;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: per-result stall plus an occasional long hold-off
    always @(posedge aclk) begin
        quant_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (quant_q.size() == 0) begin
                    $error("unexpected result quantized=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = quant_q.pop_front();
                    if (m_tdata !== want.quantized) begin
                        $error("quantized expected %h actual %h", want.quantized, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("is_last_out expected %b actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one write transaction, then the configuration channel is left idle before returning
    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fq_pkg::CFG_SCALE:  scale_reg  = val;
            fq_pkg::CFG_OFFSET: offset_reg = val;
            fq_pkg::CFG_FORMAT: format_reg = val[1:0];
            default:            width_reg  = val[1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic add_sample(logic [63:0] raw);
        sample_t it;
        it.raw  = raw;
        it.last = 1'($urandom_range(0, 1));
        sample_q.push_back(it);
    endtask

    // sample at the falling edge, after every process of the rising edge has settled
    task automatic drain();
        while (sample_q.size() != 0 || s_tvalid || quant_q.size() != 0) @(negedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // mostly values in a useful exponent band, some raw noise
    function automatic logic [63:0] random_sample(logic [1:0] fmt);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 7) begin
            if (fmt == fq_pkg::FMT_HALF) r[14:10] = 5'($urandom_range(8, 24));
            else if (fmt == fq_pkg::FMT_SINGLE) r[30:23] = 8'($urandom_range(110, 160));
            else r[62:52] = 11'($urandom_range(1000, 1060));
        end
        return r;
    endfunction

    function automatic logic [63:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return $realtobits(1.0);
            1: return $realtobits(0.5);
            2: return $realtobits(100.0);
            3: return $realtobits(0.001);
            4: return $realtobits(-3.75);
            5: return 64'h7FEFFFFFFFFFFFFF;
            6: return 64'h0000000000000001;
            7: return 64'hFFFFFFFFFFFFFFFF;
            8: return 64'h0000000000000000;
            default: return {1'($urandom), 11'($urandom_range(1013, 1033)),
                             20'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return $realtobits(1.5);
            2: return $realtobits(-1000.0);
            3: return 64'h7FF0000000000000;
            4: return 64'h7FEFFFFFFFFFFFFF;
            default: return $realtobits(real'($urandom_range(0, 2000)) / 8.0 - 125.0);
        endcase
    endfunction

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = fq_pkg::CFG_SCALE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        fail_count = 0;
        tx_burst  = 1'b0;
        rx_burst  = 1'b0;
        hold_req  = 1'b0;
        scale_reg  = 64'h3FF0000000000000;
        offset_reg = 64'd0;
        format_reg = fq_pkg::FMT_SINGLE;
        width_reg  = fq_pkg::TW_INT8;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: single in, int8 out; ties, bounds, specials
        add_sample(64'h40200000);          // 2.5
        add_sample(64'hC0200000);          // -2.5
        add_sample(64'h42FF0000);          // 127.5 clamps
        add_sample(64'h42FE0000);          // 127
        add_sample(64'hC3008000);          // -128.5 clamps
        add_sample(64'hC3000000);          // -128
        add_sample(64'hFFFFFFFF_7F800000); // +inf, high bits ignored
        add_sample(64'hFF800000);
        add_sample(64'h7FC00000);
        add_sample(64'h00000001);          // smallest subnormal
        add_sample(64'h80000000);
        add_sample(64'h3EFFFFFF);          // just under a half
        drain();
        write_reg(fq_pkg::CFG_FORMAT, 64'(fq_pkg::FMT_HALF));
        write_reg(fq_pkg::CFG_TWIDTH, 64'(fq_pkg::TW_INT16));
        add_sample(64'h7BFF);              // half max
        add_sample(64'hFBFF);
        add_sample(64'h7E00);
        add_sample(64'h0001);
        add_sample(64'h83FF);
        add_sample(64'h4100);              // 2.5
        drain();
        write_reg(fq_pkg::CFG_FORMAT, 64'(fq_pkg::FMT_DOUBLE));
        write_reg(fq_pkg::CFG_TWIDTH, 64'(fq_pkg::TW_INT32));
        write_reg(fq_pkg::CFG_SCALE, $realtobits(1.0));
        write_reg(fq_pkg::CFG_OFFSET, 64'd0);
        add_sample($realtobits(2147483647.5));
        add_sample($realtobits(-2147483648.5));
        add_sample($realtobits(-2147483648.4));
        add_sample(64'hFFFFFFFFFFFFFFFF);
        add_sample(64'h7FEFFFFFFFFFFFFF);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(fq_pkg::CFG_SCALE, pick_scale());
            write_reg(fq_pkg::CFG_OFFSET, pick_offset());
            write_reg(fq_pkg::CFG_FORMAT, 64'($urandom_range(0, 3)));
            write_reg(fq_pkg::CFG_TWIDTH, 64'($urandom_range(0, 3)));
            tx_burst = (ph % 3 == 1);
            rx_burst = (ph % 4 == 2);
            for (int k = 0; k < 40; k++) add_sample(random_sample(format_reg));
            if (ph == 5) begin
                @(negedge aclk);
                hold_req = 1'b1;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fq_pkg.sv
hw/rtl/fq_dsub.sv
hw/rtl/fq_mulq.sv
hw/rtl/float_to_int_quantizer.sv
tb/sv/float_to_int_quantizer_tb.sv
